/* rtl/core/assert_macros.svh */
// Assertion macros used by the checker file.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define PSI_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("psi assertion failed");

// Next-cycle implication, disabled while reset is high.
`define PSI_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("psi assertion failed");

// Next-cycle implication that also holds across reset.
`define PSI_ASSERT_NXT_ALL(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("psi assertion failed");

`endif

/* rtl/core/psi_pkg.sv */
// Types and constants for the per-source position integrator.
// No dependencies.
package psi_pkg;

  typedef struct packed {
    logic        [31:0] src_index;
    logic signed [31:0] in_pos_x;
    logic signed [31:0] in_pos_y;
    logic signed [31:0] in_vel_x;
    logic signed [31:0] in_vel_y;
    logic        [31:0] in_sequence;
    logic        [63:0] in_time;
    logic signed [63:0] dt_ns;
  } in_word_t;

  typedef struct packed {
    logic        [1:0]  status;
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
  } out_word_t;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_BAD_SOURCE = 2'd1;
  localparam logic [1:0] ST_BAD_DT     = 2'd2;
  localparam logic [1:0] ST_RANGE      = 2'd3;

  // 1e9 = 2^9 * 1953125: drop nine low bits, then divide by the odd factor
  // with a reciprocal; the estimate is low by at most one
  localparam logic [21:0] DIV_ODD = 22'd1953125;
  localparam logic [31:0] RECIP   = 32'd2305843009;  // floor(2^52 / 1953125)

  // table entry: {valid, time, sequence, vel_y, vel_x, pos_y, pos_x}
  localparam int ENTRY_W = 225;

  typedef struct packed {
    logic clear_step;
    logic load;
    logic look;
    logic mul_lo;
    logic mul_hi;
    logic sum;
    logic recip;
    logic q_est;
    logic back_sub;
    logic q_fix;
    logic finish;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic out_free;
  } stat_t;

endpackage

/* rtl/core/psi_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module psi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [AW-1:0]         waddr,
  input  logic [WIDTH-1:0]      wdata,
  input  logic [AW-1:0]         raddr,
  output logic [WIDTH-1:0]      rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* rtl/core/psi_ctrl.sv */
// Sequencer for the position integrator: clear pass, then one sample at a time.
// Depends on psi_pkg.
module psi_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          sample_valid,
  input  psi_pkg::stat_t stat,
  output logic          sample_stall,
  output psi_pkg::cmd_t cmd
);
  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_LOOK, S_MUL_LO, S_MUL_HI, S_SUM, S_RECIP, S_QEST, S_BACK, S_FIX,
    S_FINISH, S_COMMIT
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      unique case (state)
        S_CLEAR:  if (stat.clear_done) state <= S_IDLE;
        S_IDLE:   if (sample_valid) state <= S_LOOK;
        S_LOOK:   state <= S_MUL_LO;
        S_MUL_LO: state <= S_MUL_HI;
        S_MUL_HI: state <= S_SUM;
        S_SUM:    state <= S_RECIP;
        S_RECIP:  state <= S_QEST;
        S_QEST:   state <= S_BACK;
        S_BACK:   state <= S_FIX;
        S_FIX:    state <= S_FINISH;
        S_FINISH: state <= S_COMMIT;
        S_COMMIT: if (stat.out_free) state <= S_IDLE;
        default:  state <= S_CLEAR;
      endcase
    end
  end

  always_comb begin
    sample_stall     = (state != S_IDLE);
    cmd              = '0;
    cmd.clear_step   = (state == S_CLEAR);
    cmd.load         = (state == S_IDLE) && sample_valid;
    cmd.look         = (state == S_LOOK);
    cmd.mul_lo       = (state == S_MUL_LO);
    cmd.mul_hi       = (state == S_MUL_HI);
    cmd.sum          = (state == S_SUM);
    cmd.recip        = (state == S_RECIP);
    cmd.q_est        = (state == S_QEST);
    cmd.back_sub     = (state == S_BACK);
    cmd.q_fix        = (state == S_FIX);
    cmd.finish       = (state == S_FINISH);
    cmd.commit       = (state == S_COMMIT) && stat.out_free;
  end
endmodule

/* rtl/core/psi_dp.sv */
// Datapath: source table, two axis lanes (split multiply, reciprocal divide by 1e9),
// range checks and the result register. Depends on psi_pkg and psi_ram.
module psi_dp #(
  parameter int MAX_SOURCES = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  psi_pkg::cmd_t       cmd,
  output psi_pkg::stat_t      stat,
  input  psi_pkg::in_word_t   sample,
  output logic                result_valid,
  input  logic                result_stall,
  output psi_pkg::out_word_t  result
);
  localparam int IDX_W = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;

  psi_pkg::in_word_t smp;

  logic [IDX_W-1:0]              clr_idx;
  logic                          clear_done;
  logic                          ram_we;
  logic [IDX_W-1:0]              ram_waddr;
  logic [psi_pkg::ENTRY_W-1:0]   ram_wdata;
  logic [psi_pkg::ENTRY_W-1:0]   ram_rdata;

  // per-lane state, lane 0 is x, lane 1 is y
  logic [31:0] vel_l    [2];
  logic [31:0] pos_in_l [2];
  logic [31:0] pos_st_l [2];
  logic [31:0] base     [2];
  logic [31:0] mag      [2];
  logic        neg      [2];
  logic [63:0] plo      [2];
  logic [62:0] phi      [2];
  logic [94:0] prod     [2];
  logic        ovf      [2];
  logic [53:0] nq       [2];
  logic [63:0] rlo      [2];
  logic [53:0] rhi      [2];
  logic [85:0] rsum     [2];
  logic [33:0] qe       [2];
  logic [55:0] back     [2];
  logic [21:0] rmd      [2];
  logic [33:0] quo      [2];
  logic [35:0] delta    [2];
  logic [35:0] npos     [2];
  logic        fail     [2];

  logic [1:0]  res_status;
  logic [31:0] res_pos [2];
  logic        bad_src;

  psi_ram #(.WIDTH(psi_pkg::ENTRY_W), .DEPTH(MAX_SOURCES)) u_tab (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (sample.src_index[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  assign vel_l[0]    = smp.in_vel_x;
  assign vel_l[1]    = smp.in_vel_y;
  assign pos_in_l[0] = smp.in_pos_x;
  assign pos_in_l[1] = smp.in_pos_y;
  assign pos_st_l[0] = ram_rdata[31:0];
  assign pos_st_l[1] = ram_rdata[63:32];
  assign bad_src     = (smp.src_index >= 32'(MAX_SOURCES));

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      prod[l]  = {phi[l], 32'b0} + {31'b0, plo[l]};
      rsum[l]  = {rhi[l], 32'b0} + {22'b0, rlo[l]};
      back[l]  = qe[l] * psi_pkg::DIV_ODD;
      delta[l] = neg[l] ? (36'd0 - {2'b0, quo[l]}) : {2'b0, quo[l]};
      npos[l]  = {{4{base[l][31]}}, base[l]} + delta[l];
      fail[l]  = ovf[l] || !((npos[l][35:31] == 5'b00000) || (npos[l][35:31] == 5'b11111));
    end
  end

  // table writes: clearing pass after reset, then committed updates of successful samples
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_idx;
    ram_wdata = '0;
    if (cmd.clear_step && !clear_done) begin
      ram_we = 1'b1;
    end else if (cmd.commit && (res_status == psi_pkg::ST_OK)) begin
      ram_we    = 1'b1;
      ram_waddr = smp.src_index[IDX_W-1:0];
      ram_wdata = {1'b1, smp.in_time, smp.in_sequence, smp.in_vel_y, smp.in_vel_x,
                   res_pos[1], res_pos[0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx    <= '0;
      clear_done <= 1'b0;
    end else if (cmd.clear_step && !clear_done) begin
      clr_idx <= clr_idx + 1'b1;
      if (clr_idx == IDX_W'(MAX_SOURCES - 1)) clear_done <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) smp <= sample;
    for (int l = 0; l < 2; l++) begin
      if (cmd.look) begin
        base[l] <= ram_rdata[psi_pkg::ENTRY_W-1] ? pos_st_l[l] : pos_in_l[l];
        neg[l]  <= vel_l[l][31];
        mag[l]  <= vel_l[l][31] ? (32'd0 - vel_l[l]) : vel_l[l];
      end
      if (cmd.mul_lo) plo[l] <= mag[l] * smp.dt_ns[31:0];
      if (cmd.mul_hi) phi[l] <= mag[l] * smp.dt_ns[62:32];
      if (cmd.sum) begin
        ovf[l] <= |prod[l][94:63];
        nq[l]  <= prod[l][62:9];
      end
      // quotient estimate by the odd factor: (nq * RECIP) >> 52, low by at most one
      if (cmd.recip) begin
        rlo[l] <= nq[l][31:0] * psi_pkg::RECIP;
        rhi[l] <= nq[l][53:32] * psi_pkg::RECIP;
      end
      if (cmd.q_est) qe[l] <= rsum[l][85:52];
      // remainder is below twice the divisor, so 22 low bits hold it exactly
      if (cmd.back_sub) rmd[l] <= nq[l][21:0] - back[l][21:0];
      if (cmd.q_fix) quo[l] <= qe[l] + 34'(rmd[l] >= psi_pkg::DIV_ODD);
    end
    if (cmd.finish) begin
      priority if (bad_src) begin
        res_status <= psi_pkg::ST_BAD_SOURCE;
      end else if (smp.dt_ns[63]) begin
        res_status <= psi_pkg::ST_BAD_DT;
      end else if (fail[0] || fail[1]) begin
        res_status <= psi_pkg::ST_RANGE;
      end else begin
        res_status <= psi_pkg::ST_OK;
      end
      res_pos[0] <= npos[0][31:0];
      res_pos[1] <= npos[1][31:0];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.commit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      result.status <= res_status;
      if (res_status == psi_pkg::ST_OK) begin
        result.new_pos_x <= res_pos[0];
        result.new_pos_y <= res_pos[1];
      end else begin
        result.new_pos_x <= '0;
        result.new_pos_y <= '0;
      end
    end
  end

  assign stat = '{clear_done: clear_done, out_free: !result_valid || !result_stall};
endmodule

/* rtl/core/per_source_position_integrator.sv */
// Per-source dead-reckoning position integrator, top level.
// Depends on psi_pkg, psi_ctrl, psi_dp (psi_ram below it).
//
// Usage:
//   sample / sample_valid / sample_stall carry one tracking sample per word;
//   result / result_valid / result_stall carry one status word back per sample.
//   A word moves on a rising edge with valid high and stall low.
// Sequence:
//   After reset the source table is cleared, one entry per cycle, and
//   sample_stall stays high until the clear pass is done.
//   A sample is then taken when the block is free; no new sample is taken
//   until its result is committed to the output register. Each sample
//   passes through the table read, two half multiplies, the sum, and the
//   divide by 1e9 done as a reciprocal multiply, a back multiply and a
//   one-step correction, plus the range check and the commit.
// Stalls:
//   The result sits in an output register; a new sample is accepted while
//   it waits. A sample whose result is ready while the previous one is
//   still stalled waits inside until the output register frees up.
module per_source_position_integrator #(
  parameter int MAX_SOURCES = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               sample_valid,
  output logic               sample_stall,
  input  psi_pkg::in_word_t  sample,
  output logic               result_valid,
  input  logic               result_stall,
  output psi_pkg::out_word_t result
);
  psi_pkg::cmd_t  cmd;
  psi_pkg::stat_t stat;

  psi_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .stat         (stat),
    .sample_stall (sample_stall),
    .cmd          (cmd)
  );

  psi_dp #(.MAX_SOURCES(MAX_SOURCES)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );
endmodule

/* rtl/core/psi_checker.sv */
// Port-level checks for the position integrator, bound to the top level.
// Depends on psi_pkg and assert_macros.svh.
`include "assert_macros.svh"

module psi_checker (
  input logic               clk,
  input logic               rst,
  input logic               sample_valid,
  input logic               sample_stall,
  input logic               result_valid,
  input logic               result_stall,
  input psi_pkg::out_word_t result
);
  // a stalled result word holds
  `PSI_ASSERT_NXT(a_res_hold, clk, rst, result_valid && result_stall, result_valid && $stable(result))
  // one sample at a time: taking a word closes the input
  `PSI_ASSERT_NXT(a_one_inflight, clk, rst, sample_valid && !sample_stall, sample_stall)
  // failed samples report a zero position
  `PSI_ASSERT_IMP(a_fail_zero, clk, rst, result_valid && (result.status != psi_pkg::ST_OK), (result.new_pos_x == 0) && (result.new_pos_y == 0))
  // reset empties the output and closes the input for the clear pass
  `PSI_ASSERT_NXT_ALL(a_reset, clk, rst, !result_valid && sample_stall)
endmodule

bind per_source_position_integrator psi_checker u_psi_checker (
  .clk          (clk),
  .rst          (rst),
  .sample_valid (sample_valid),
  .sample_stall (sample_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);
